### src/hcld_pkg.sv
// ----------------------------------------------------------------------------
// hcld_pkg
// Shared types, constants and helper functions for the hex command line
// decoder.
// ----------------------------------------------------------------------------
package hcld_pkg;

  localparam int unsigned LINE_DEPTH     = 256;
  localparam int unsigned KEPT_POSITIONS = 10;
  localparam int unsigned KEEP_LIMIT     =
    (LINE_DEPTH < KEPT_POSITIONS) ? LINE_DEPTH : KEPT_POSITIONS;
  localparam int unsigned FILL_W         = $clog2(KEPT_POSITIONS + 1);
  localparam int unsigned IDX_W          = $clog2(KEPT_POSITIONS);

  localparam logic [7:0] CHAR_TERM   = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_PREFIX = 8'h47;  // 'G'
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  // Command numbers, matched as decimal values of the hex-decoded field.
  localparam logic [15:0] CMD_PWR_ON    = 16'd1;
  localparam logic [15:0] CMD_PWR_OFF   = 16'd2;
  localparam logic [15:0] CMD_FET_ON    = 16'd3;
  localparam logic [15:0] CMD_FET_OFF   = 16'd4;
  localparam logic [15:0] CMD_VOLT      = 16'd21;
  localparam logic [15:0] CMD_CURRENT   = 16'd22;
  localparam logic [15:0] CMD_TEMP      = 16'd23;
  localparam logic [15:0] CMD_SET_LIMIT = 16'd33;
  localparam logic [15:0] CMD_RD_SERIAL = 16'd10;
  localparam logic [15:0] CMD_WR_SERIAL = 16'd11;
  localparam logic [15:0] CMD_STATS     = 16'd12;

  typedef enum logic [3:0] {
    ACT_PWR_ON     = 4'd0,
    ACT_PWR_OFF    = 4'd1,
    ACT_FET_ON     = 4'd2,
    ACT_FET_OFF    = 4'd3,
    ACT_VOLT       = 4'd4,
    ACT_CURRENT    = 4'd5,
    ACT_TEMP       = 4'd6,
    ACT_SET_LIMIT  = 4'd7,
    ACT_RD_SERIAL  = 4'd8,
    ACT_WR_SERIAL  = 4'd9,
    ACT_STATS      = 4'd10,
    ACT_UNKNOWN    = 4'd11,
    ACT_BAD_PREFIX = 4'd12
  } action_e;

  typedef logic [KEPT_POSITIONS-1:0][7:0] line_t;

  typedef struct packed {
    logic fet_led;
    logic power_led;
    logic charge_fet;
    logic power_enable;
  } pin_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] argument;
    pin_t        pins;
  } result_t;

  // Uppercase hex digit value; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = c - 8'd48;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = c - 8'd55;
    end
    return v[3:0];
  endfunction

endpackage

### src/hex_command_line_decoder.sv
// ----------------------------------------------------------------------------
// hex_command_line_decoder
// Character-at-a-time command line decoder with pin control outputs.
// ----------------------------------------------------------------------------
// Each accepted transaction on the input channel carries one received byte.
// Bytes are captured in an input register and from there appended to
// a ten-position line store (zero bytes and bytes past the kept positions
// are dropped). A ';' closes the line: the store is decoded in that same
// cycle, the power-enable and charge-FET levels with their LEDs are updated,
// and one result transaction (action code, argument, pin levels) is loaded
// into the output register while the store is cleared. Any other byte
// produces no result. The block takes one byte per cycle unless a ';' is
// stalled; the result of a ';' goes through the input and output registers.
// Only the output register stalls: while it holds a result that has not
// been taken, a ';' waits in the input register and holds off the input
// channel until the result is taken. Other bytes never wait on the output.
module hex_command_line_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [15:0] argument_o,
  output logic        power_enable_o,
  output logic        charge_fet_o,
  output logic        power_led_o,
  output logic        fet_led_o
);
  import hcld_pkg::*;

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;

  // Pin levels and output register.
  pin_t    pins_q;
  result_t out_q;
  logic    out_vld_q, out_vld_d;

  logic    is_term;
  logic    out_free;
  logic    advance;
  logic    in_fire;
  line_t   line;
  result_t dec;

  assign is_term  = (in_char_q == CHAR_TERM);
  assign out_free = !out_vld_q || out_ready_i;
  // A non-terminator byte never needs the output register.
  assign advance  = in_vld_q && (!is_term || out_free);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire  = in_valid_i && in_ready_o;

  hcld_line_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance && !is_term),
    .clear_i (advance && is_term),
    .char_i  (in_char_q),
    .line_o  (line)
  );

  hcld_decode u_decode (
    .line_i   (line),
    .pins_i   (pins_q),
    .result_o (dec)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && is_term) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pins_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance && is_term) begin
        pins_q <= dec.pins;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= character_i;
    end
    if (advance && is_term) begin
      out_q <= dec;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign action_o       = out_q.action;
  assign argument_o     = out_q.argument;
  assign power_enable_o = out_q.pins.power_enable;
  assign charge_fet_o   = out_q.pins.charge_fet;
  assign power_led_o    = out_q.pins.power_led;
  assign fet_led_o      = out_q.pins.fet_led;

endmodule

### src/hcld_line_store.sv
// ----------------------------------------------------------------------------
// hcld_line_store
// Holds the first positions of the current command line and the fill count.
// ----------------------------------------------------------------------------
module hcld_line_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           clear_i,
  input  logic [7:0]     char_i,
  output hcld_pkg::line_t line_o
);
  import hcld_pkg::*;

  line_t             chars_q, chars_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              keep;

  // Zero bytes are never stored, since zero marks an empty position.
  assign keep = push_i && (char_i != CHAR_NUL) && (fill_q < FILL_W'(KEEP_LIMIT));

  always_comb begin
    chars_d = chars_q;
    fill_d  = fill_q;
    if (clear_i) begin
      chars_d = '0;
      fill_d  = '0;
    end else if (keep) begin
      chars_d[fill_q[IDX_W-1:0]] = char_i;
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      fill_q  <= '0;
    end else begin
      chars_q <= chars_d;
      fill_q  <= fill_d;
    end
  end

  assign line_o = chars_q;

endmodule

### src/hcld_decode.sv
// ----------------------------------------------------------------------------
// hcld_decode
// Decodes a finished command line into an action, an argument and the new
// pin levels.
// ----------------------------------------------------------------------------
module hcld_decode (
  input  hcld_pkg::line_t   line_i,
  input  hcld_pkg::pin_t    pins_i,
  output hcld_pkg::result_t result_o
);
  import hcld_pkg::*;

  logic [15:0] number;
  logic [15:0] arg;

  assign number = {hex_value(line_i[1]), hex_value(line_i[2]),
                   hex_value(line_i[3]), hex_value(line_i[4])};
  assign arg    = {hex_value(line_i[6]), hex_value(line_i[7]),
                   hex_value(line_i[8]), hex_value(line_i[9])};

  always_comb begin
    result_o.argument = arg;
    result_o.pins     = pins_i;
    result_o.action   = ACT_BAD_PREFIX;
    if (line_i[0] == CHAR_PREFIX) begin
      case (number)
        CMD_PWR_ON: begin
          result_o.action             = ACT_PWR_ON;
          result_o.pins.power_enable  = 1'b1;
          result_o.pins.power_led     = 1'b1;
        end
        CMD_PWR_OFF: begin
          result_o.action             = ACT_PWR_OFF;
          result_o.pins.power_enable  = 1'b0;
          result_o.pins.power_led     = 1'b0;
        end
        CMD_FET_ON: begin
          result_o.action             = ACT_FET_ON;
          result_o.pins.charge_fet    = 1'b1;
          result_o.pins.fet_led       = 1'b1;
        end
        CMD_FET_OFF: begin
          result_o.action             = ACT_FET_OFF;
          result_o.pins.charge_fet    = 1'b0;
          result_o.pins.fet_led       = 1'b0;
        end
        CMD_VOLT:      result_o.action = ACT_VOLT;
        CMD_CURRENT:   result_o.action = ACT_CURRENT;
        CMD_TEMP:      result_o.action = ACT_TEMP;
        CMD_SET_LIMIT: result_o.action = ACT_SET_LIMIT;
        CMD_RD_SERIAL: result_o.action = ACT_RD_SERIAL;
        CMD_WR_SERIAL: result_o.action = ACT_WR_SERIAL;
        CMD_STATS:     result_o.action = ACT_STATS;
        default:       result_o.action = ACT_UNKNOWN;
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the hex command line decoder.
// ----------------------------------------------------------------------------
// Characters are sent one per transaction from a queue that is filled before
// reset is released. Every character that the decoder accepts is run through
// a predictor of the line store and the pin state. Each ';' leaves one
// expected command reply behind, and the replies that the decoder returns are
// checked field by field in arrival order. The stimulus opens with a few
// hand-written lines. These cover a maximum argument, a dropped zero byte, an
// over-long line, lowercase and other non-hex digits, a missing 'G', an empty
// line and high-bit bytes. The bulk is random: mostly well-formed command
// lines with random arguments, plus truncated or padded lines and raw noise.
// Both channels idle in random bursts that grow and shrink over the run, and
// the tail of the run has no idling at all.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcld_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1800;
  localparam int unsigned CALM_CHARS   = 120;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned SETTLE_TIME  = 8;

  // One entry of the send queue. A flagged entry carries no character: it
  // makes the sender hold off until every reply in flight has been checked.
  typedef struct packed {
    logic       drain;
    logic [7:0] ch;
  } tx_entry_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  character_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [3:0]  action_o;
  logic [15:0] argument_o;
  logic        power_enable_o;
  logic        charge_fet_o;
  logic        power_led_o;
  logic        fet_led_o;

  tx_entry_t   rx_char_q [$];
  result_t     reply_q [$];

  // Shadow copy of the decoder state that the predictor advances.
  logic [7:0]  line_buf [KEPT_POSITIONS];
  int unsigned line_fill = 0;
  pin_t        pin_state = '0;

  // Handshake bookkeeping and the current idling pressure.
  logic        in_fire    = 1'b0;
  logic        drain_wait = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned idle_pct   = 0;
  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  // Command numbers in the order of their action codes. Each number is sent
  // as its own hex digits, so 33 goes out as "0021".
  logic [15:0] known_cmds [11] = '{CMD_PWR_ON, CMD_PWR_OFF, CMD_FET_ON,
                                   CMD_FET_OFF, CMD_VOLT, CMD_CURRENT,
                                   CMD_TEMP, CMD_SET_LIMIT, CMD_RD_SERIAL,
                                   CMD_WR_SERIAL, CMD_STATS};

  hex_command_line_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .argument_o     (argument_o),
    .power_enable_o (power_enable_o),
    .charge_fet_o   (charge_fet_o),
    .power_led_o    (power_led_o),
    .fet_led_o      (fet_led_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Only uppercase hex digits carry a value. Everything else, including an
  // empty position and lowercase letters, reads as zero.
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [15:0] field_at(input int unsigned first);
    logic [15:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      v = {v[11:0], digit_of(line_buf[(first + k) % KEPT_POSITIONS])};
    end
    return v;
  endfunction

  // Advances the shadow state by one accepted character. Returns 1 and the
  // expected reply when the character closes a line.
  function automatic bit decode_char(input logic [7:0] ch, output result_t reply);
    logic [15:0] number;
    action_e     act;
    reply = '0;
    if (ch != CHAR_TERM) begin
      // Zero bytes never enter the store, and a full store drops the rest.
      if (ch != CHAR_NUL && line_fill < KEEP_LIMIT) begin
        line_buf[line_fill] = ch;
        line_fill++;
      end
      return 1'b0;
    end
    number = field_at(1);
    reply.argument = field_at(6);
    if (line_buf[0] != CHAR_PREFIX) begin
      act = ACT_BAD_PREFIX;
    end else begin
      case (number)
        CMD_PWR_ON: begin
          pin_state.power_enable = 1'b1;
          pin_state.power_led    = 1'b1;
          act = ACT_PWR_ON;
        end
        CMD_PWR_OFF: begin
          pin_state.power_enable = 1'b0;
          pin_state.power_led    = 1'b0;
          act = ACT_PWR_OFF;
        end
        CMD_FET_ON: begin
          pin_state.charge_fet = 1'b1;
          pin_state.fet_led    = 1'b1;
          act = ACT_FET_ON;
        end
        CMD_FET_OFF: begin
          pin_state.charge_fet = 1'b0;
          pin_state.fet_led    = 1'b0;
          act = ACT_FET_OFF;
        end
        CMD_VOLT:      act = ACT_VOLT;
        CMD_CURRENT:   act = ACT_CURRENT;
        CMD_TEMP:      act = ACT_TEMP;
        CMD_SET_LIMIT: act = ACT_SET_LIMIT;
        CMD_RD_SERIAL: act = ACT_RD_SERIAL;
        CMD_WR_SERIAL: act = ACT_WR_SERIAL;
        CMD_STATS:     act = ACT_STATS;
        default:       act = ACT_UNKNOWN;
      endcase
    end
    reply.action = act;
    reply.pins   = pin_state;
    // Every closed line empties the store, whether it decoded or not.
    for (int i = 0; i < KEPT_POSITIONS; i++) begin
      line_buf[i] = CHAR_NUL;
    end
    line_fill = 0;
    return 1'b1;
  endfunction

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      fail_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] ch);
    rx_char_q.push_back(tx_entry_t'{drain: 1'b0, ch: ch});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  task automatic push_drain();
    rx_char_q.push_back(tx_entry_t'{drain: 1'b1, ch: CHAR_NUL});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return "0" + 8'(n);
    end
    return (lower ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  // Any byte except the terminator; zero is allowed and gets dropped.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_TERM);
    return c;
  endfunction

  task automatic push_hex4(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(99) < 8) begin
        push_char(filler_char());
      end else begin
        push_char(hex_char(v[4*i +: 4], 1'b0));
      end
    end
  endtask

  task automatic add_random_line();
    int unsigned kind;
    int unsigned len;
    logic [15:0] number;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // Well-formed line: 'G', command number, separator, argument, ';'.
      if ($urandom_range(99) < 10) begin
        number = 16'($urandom_range(0, 16'hFFFF));
      end else begin
        number = known_cmds[$urandom_range(0, 10)];
      end
      push_char(CHAR_PREFIX);
      push_hex4(number);
      push_char(filler_char());
      push_hex4(16'($urandom_range(0, 16'hFFFF)));
      if ($urandom_range(99) < 10) begin
        push_char(filler_char());
      end
      push_char(CHAR_TERM);
    end else if (kind < 85) begin
      // Truncated or padded line with a valid prefix.
      push_char(CHAR_PREFIX);
      len = $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0, 1:    push_char(hex_char(4'($urandom_range(0, 15)), 1'b0));
          2:       push_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
          default: push_char(filler_char());
        endcase
      end
      push_char(CHAR_TERM);
    end else begin
      // Raw noise; a stray ';' inside closes an extra line.
      len = $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
        push_char(8'($urandom_range(0, 255)));
      end
      push_char(CHAR_TERM);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer: fills the send queue, releases reset, waits for the end.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    bit mid_drain_done;
    mid_drain_done = 1'b0;
    for (int i = 0; i < KEPT_POSITIONS; i++) begin
      line_buf[i] = CHAR_NUL;
    end

    // Power on with the largest argument.
    push_text("G0001.FFFF;");
    // A zero byte in the middle of a line is dropped; the line is short.
    push_text("G0003");
    push_char(CHAR_NUL);
    push_text(";");
    // Set limit (hex "0021" read as 33), lowercase digit, over-long line.
    push_text("G0021x9a0FZZ;");
    // Missing 'G', empty line, and a line made only of a high-bit byte.
    push_text("g;");
    push_text(";");
    push_char(8'hFF);
    push_char(CHAR_TERM);
    // Let everything settle before the random part starts.
    push_drain();

    while (rx_char_q.size() < RANDOM_CHARS) begin
      add_random_line();
      if (!mid_drain_done && rx_char_q.size() >= RANDOM_CHARS / 2) begin
        push_drain();
        mid_drain_done = 1'b1;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every character is sent and every reply has come back.
    while (rx_char_q.size() != 0 || in_valid_i || drain_wait || reply_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_TIME) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Character driver. Runs on the falling edge. A presented character stays
  // put until the transaction completes; after that the driver may insert an
  // idle burst, honor a drain request, or present the next character.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : char_driver
    tx_entry_t entry;
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
        // Still waiting for the decoder to take the current character.
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (drain_wait) begin
        in_valid_i <= 1'b0;
        if (reply_q.size() == 0) begin
          drain_wait = 1'b0;
        end
      end else if (rx_char_q.size() != 0) begin
        entry = rx_char_q.pop_front();
        if (entry.drain) begin
          in_valid_i <= 1'b0;
          drain_wait = 1'b1;
        end else begin
          in_valid_i  <= 1'b1;
          character_i <= entry.ch;
          if ($urandom_range(99) < idle_pct) begin
            send_gap = $urandom_range(1, 13);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Reply sink: ready drops in random bursts, also on the falling edge.
  always @(negedge clk_i) begin : reply_sink
    if (rst_ni) begin
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(99) < idle_pct) begin
          stall_left = $urandom_range(1, 13);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Samples both channels on the rising edge. A completed reply
  // transaction is checked against the oldest expectation before the
  // character taken at the same edge is predicted, so the ordering of the
  // reply queue never depends on process scheduling.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t ns: unexpected reply, expected none, actual action %0d argument %0h",
                   $time, action_o, argument_o);
          fail_cnt++;
        end else begin
          want = reply_q.pop_front();
          check_field("action", 16'(want.action), 16'(action_o));
          check_field("argument", want.argument, argument_o);
          check_field("power_enable", 16'(want.pins.power_enable), 16'(power_enable_o));
          check_field("charge_fet", 16'(want.pins.charge_fet), 16'(charge_fet_o));
          check_field("power_led", 16'(want.pins.power_led), 16'(power_led_o));
          check_field("fet_led", 16'(want.pins.fet_led), 16'(fet_led_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (decode_char(character_i, want)) begin
          reply_q.push_back(want);
        end
      end
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;

    // Idling pressure moves through bands as the send queue drains, with a
    // quiet band among them; the tail of the run has no idling.
    if (rx_char_q.size() < CALM_CHARS) begin
      idle_pct <= 0;
    end else begin
      case ((rx_char_q.size() / 150) % 4)
        0:       idle_pct <= 0;
        1:       idle_pct <= 8;
        2:       idle_pct <= 25;
        default: idle_pct <= 50;
      endcase
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

### files.f
src/hcld_pkg.sv
src/hcld_line_store.sv
src/hcld_decode.sv
src/hex_command_line_decoder.sv
tb/sv/testbench.sv
